// File: rtl/core/lsrc_pkg.sv
// Package for the line segment rectangle clipper.
// Holds coordinate widths, payload and pipeline context types, and register codes.
// No dependencies.
`default_nettype none
package lsrc_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int ADDR_W  = 4;

    localparam logic [1:0] REG_MIN_X = 2'd0;
    localparam logic [1:0] REG_MAX_X = 2'd1;
    localparam logic [1:0] REG_MIN_Y = 2'd2;
    localparam logic [1:0] REG_MAX_Y = 2'd3;

    localparam logic signed [COORD_W-1:0] RST_MIN_X = COORD_W'(0);
    localparam logic signed [COORD_W-1:0] RST_MAX_X = COORD_W'(4095);
    localparam logic signed [COORD_W-1:0] RST_MIN_Y = COORD_W'(0);
    localparam logic signed [COORD_W-1:0] RST_MAX_Y = COORD_W'(4095);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } lsrc_in_t;

    typedef struct packed {
        logic                      visible;
        logic signed [COORD_W-1:0] clip_start_x;
        logic signed [COORD_W-1:0] clip_start_y;
        logic signed [COORD_W-1:0] clip_end_x;
        logic signed [COORD_W-1:0] clip_end_y;
    } lsrc_out_t;

    typedef struct packed {
        lsrc_in_t                  item;
        logic                      swap;
        logic                      live;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } lsrc_ctx_t;

    typedef struct packed {
        lsrc_ctx_t                 ctx;
        logic signed [COORD_W-1:0] base;
        logic                      neg;
        logic [DIFF_W-1:0]         d;
    } lsrc_side_t;

endpackage
`default_nettype wire

// File: rtl/core/lsrc_mul_cell.sv
// One shift-add step of the magnitude multiplier chain.
// Depends on lsrc_pkg.
`default_nettype none
module lsrc_mul_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      adv,
    input  wire logic                      valid_i,
    input  wire lsrc_pkg::lsrc_side_t      side_i,
    input  wire logic [lsrc_pkg::DIFF_W-1:0] a_i,
    input  wire logic [lsrc_pkg::PROD_W-1:0] b_i,
    input  wire logic [lsrc_pkg::PROD_W-1:0] acc_i,
    output logic                           valid_o,
    output lsrc_pkg::lsrc_side_t           side_o,
    output logic [lsrc_pkg::DIFF_W-1:0]    a_o,
    output logic [lsrc_pkg::PROD_W-1:0]    b_o,
    output logic [lsrc_pkg::PROD_W-1:0]    acc_o
);
    import lsrc_pkg::*;

    logic              valid_reg;
    lsrc_side_t        side_reg;
    logic [DIFF_W-1:0] a_reg;
    logic [PROD_W-1:0] b_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] acc_next;

    assign acc_next = acc_i + (a_i[0] ? b_i : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= side_i;
            a_reg    <= a_i >> 1;
            b_reg    <= b_i << 1;
            acc_reg  <= acc_next;
        end
    end

    assign valid_o = valid_reg;
    assign side_o  = side_reg;
    assign a_o     = a_reg;
    assign b_o     = b_reg;
    assign acc_o   = acc_reg;
endmodule
`default_nettype wire

// File: rtl/core/lsrc_div_cell.sv
// One restoring step of the quotient divider chain.
// Depends on lsrc_pkg.
`default_nettype none
module lsrc_div_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        adv,
    input  wire logic                        valid_i,
    input  wire lsrc_pkg::lsrc_side_t        side_i,
    input  wire logic [lsrc_pkg::PROD_W-1:0] prod_i,
    input  wire logic [lsrc_pkg::DIFF_W-1:0] rem_i,
    input  wire logic [lsrc_pkg::COORD_W-1:0] quo_i,
    output logic                             valid_o,
    output lsrc_pkg::lsrc_side_t             side_o,
    output logic [lsrc_pkg::PROD_W-1:0]      prod_o,
    output logic [lsrc_pkg::DIFF_W-1:0]      rem_o,
    output logic [lsrc_pkg::COORD_W-1:0]     quo_o
);
    import lsrc_pkg::*;

    logic               valid_reg;
    lsrc_side_t         side_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DIFF_W-1:0]  rem_reg;
    logic [COORD_W-1:0] quo_reg;
    logic [DIFF_W:0]    trial;
    logic               take;
    logic [DIFF_W-1:0]  rem_next;

    always_comb begin
        trial    = {rem_i, prod_i[PROD_W-1]};
        take     = (trial >= {1'b0, side_i.d});
        rem_next = take ? DIFF_W'(trial - {1'b0, side_i.d}) : trial[DIFF_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= side_i;
            prod_reg <= prod_i << 1;
            rem_reg  <= rem_next;
            quo_reg  <= {quo_i[COORD_W-2:0], take};
        end
    end

    assign valid_o = valid_reg;
    assign side_o  = side_reg;
    assign prod_o  = prod_reg;
    assign rem_o   = rem_reg;
    assign quo_o   = quo_reg;
endmodule
`default_nettype wire

// File: rtl/core/lsrc_interp.sv
// Interpolation pipeline: base + (a1-a2)*(b1-b2)/(c1-c2), truncated toward zero.
// Chains lsrc_mul_cell and lsrc_div_cell; depends on lsrc_pkg.
`default_nettype none
module lsrc_interp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 valid_i,
    input  wire lsrc_pkg::lsrc_ctx_t  ctx_i,
    input  wire lsrc_pkg::coord_t     base_i,
    input  wire lsrc_pkg::coord_t     a1_i,
    input  wire lsrc_pkg::coord_t     a2_i,
    input  wire lsrc_pkg::coord_t     b1_i,
    input  wire lsrc_pkg::coord_t     b2_i,
    input  wire lsrc_pkg::coord_t     c1_i,
    input  wire lsrc_pkg::coord_t     c2_i,
    output logic                      valid_o,
    output lsrc_pkg::lsrc_ctx_t       ctx_o,
    output lsrc_pkg::coord_t          res_o
);
    import lsrc_pkg::*;

    logic signed [DIFF_W-1:0] da, db, dc;
    logic [DIFF_W-1:0]        ma, mb, mc;
    lsrc_side_t               side_next;

    logic              mul_v   [0:DIFF_W];
    lsrc_side_t        mul_s   [0:DIFF_W];
    logic [DIFF_W-1:0] mul_a   [0:DIFF_W];
    logic [PROD_W-1:0] mul_b   [0:DIFF_W];
    logic [PROD_W-1:0] mul_acc [0:DIFF_W];

    logic               div_v [0:PROD_W];
    lsrc_side_t         div_s [0:PROD_W];
    logic [PROD_W-1:0]  div_p [0:PROD_W];
    logic [DIFF_W-1:0]  div_r [0:PROD_W];
    logic [COORD_W-1:0] div_q [0:PROD_W];

    logic               valid_reg;
    lsrc_ctx_t          ctx_reg;
    coord_t             res_reg;
    coord_t             res_next;
    logic [COORD_W-1:0] q_signed;

    always_comb begin
        da = DIFF_W'(a1_i) - DIFF_W'(a2_i);
        db = DIFF_W'(b1_i) - DIFF_W'(b2_i);
        dc = DIFF_W'(c1_i) - DIFF_W'(c2_i);
        ma = da[DIFF_W-1] ? DIFF_W'(-da) : DIFF_W'(da);
        mb = db[DIFF_W-1] ? DIFF_W'(-db) : DIFF_W'(db);
        mc = dc[DIFF_W-1] ? DIFF_W'(-dc) : DIFF_W'(dc);
        side_next.ctx  = ctx_i;
        side_next.base = base_i;
        side_next.neg  = da[DIFF_W-1] ^ db[DIFF_W-1] ^ dc[DIFF_W-1];
        side_next.d    = mc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v[0] <= 1'b0;
        end else if (adv) begin
            mul_v[0] <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mul_s[0]   <= side_next;
            mul_a[0]   <= ma;
            mul_b[0]   <= PROD_W'(mb);
            mul_acc[0] <= '0;
        end
    end

    for (genvar i = 0; i < DIFF_W; i++) begin : g_mul
        lsrc_mul_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .valid_i (mul_v[i]),
            .side_i  (mul_s[i]),
            .a_i     (mul_a[i]),
            .b_i     (mul_b[i]),
            .acc_i   (mul_acc[i]),
            .valid_o (mul_v[i+1]),
            .side_o  (mul_s[i+1]),
            .a_o     (mul_a[i+1]),
            .b_o     (mul_b[i+1]),
            .acc_o   (mul_acc[i+1])
        );
    end

    assign div_v[0] = mul_v[DIFF_W];
    assign div_s[0] = mul_s[DIFF_W];
    assign div_p[0] = mul_acc[DIFF_W];
    assign div_r[0] = '0;
    assign div_q[0] = '0;

    for (genvar j = 0; j < PROD_W; j++) begin : g_div
        lsrc_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .valid_i (div_v[j]),
            .side_i  (div_s[j]),
            .prod_i  (div_p[j]),
            .rem_i   (div_r[j]),
            .quo_i   (div_q[j]),
            .valid_o (div_v[j+1]),
            .side_o  (div_s[j+1]),
            .prod_o  (div_p[j+1]),
            .rem_o   (div_r[j+1]),
            .quo_o   (div_q[j+1])
        );
    end

    always_comb begin
        q_signed = div_s[PROD_W].neg ? COORD_W'(-div_q[PROD_W]) : div_q[PROD_W];
        if (div_s[PROD_W].d == '0) begin
            res_next = div_s[PROD_W].base;
        end else begin
            res_next = coord_t'(div_s[PROD_W].base + q_signed);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= div_v[PROD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctx_reg <= div_s[PROD_W].ctx;
            res_reg <= res_next;
        end
    end

    assign valid_o = valid_reg;
    assign ctx_o   = ctx_reg;
    assign res_o   = res_reg;
endmodule
`default_nettype wire

// File: rtl/core/line_segment_rect_clipper.sv
// Line segment rectangle clipper, top level: APB register file, decode, four
// interpolation pipelines and the output register. Depends on lsrc_pkg, lsrc_interp.
//
// One segment enters per clock unless the output stalls. Its path is one decode
// stage, four interpolation pipelines of 101 stages each (operand stage, 33
// shift-add multiplier cells, 66 restoring divider cells, result stage) and the
// output register. The whole pipeline holds while a result waits on m_ready.
// Region registers are read live along the pipeline, so write them only when idle.
`default_nettype none
module line_segment_rect_clipper (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire lsrc_pkg::lsrc_in_t           s_payload,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output lsrc_pkg::lsrc_out_t               m_payload,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lsrc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import lsrc_pkg::*;

    coord_t min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic   adv;
    logic   [1:0] reg_idx;

    logic       v0_reg;
    lsrc_ctx_t  ctx0_reg, ctx0_next;

    logic       va, vb, vc, vd;
    lsrc_ctx_t  ca, cb, cc, cd;
    coord_t     ra, rb, rc, rd;
    lsrc_ctx_t  ca_next, cb_next, cc_next, cd_next;
    coord_t     bound_c, bound_d;

    logic       m_valid_reg;
    lsrc_out_t  m_payload_reg, m_payload_next;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= RST_MIN_X;
            max_x_reg <= RST_MAX_X;
            min_y_reg <= RST_MIN_Y;
            max_y_reg <= RST_MAX_Y;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_MIN_X: min_x_reg <= coord_t'(pwdata);
                REG_MAX_X: max_x_reg <= coord_t'(pwdata);
                REG_MIN_Y: min_y_reg <= coord_t'(pwdata);
                REG_MAX_Y: max_y_reg <= coord_t'(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_X: prdata = min_x_reg;
            REG_MAX_X: prdata = max_x_reg;
            REG_MIN_Y: prdata = min_y_reg;
            REG_MAX_Y: prdata = max_y_reg;
            default:   prdata = '0;
        endcase
    end

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_comb begin
        ctx0_next.item = s_payload;
        ctx0_next.swap = s_payload.end_x < s_payload.start_x;
        if (ctx0_next.swap) begin
            ctx0_next.x1 = s_payload.end_x;
            ctx0_next.y1 = s_payload.end_y;
            ctx0_next.x2 = s_payload.start_x;
            ctx0_next.y2 = s_payload.start_y;
        end else begin
            ctx0_next.x1 = s_payload.start_x;
            ctx0_next.y1 = s_payload.start_y;
            ctx0_next.x2 = s_payload.end_x;
            ctx0_next.y2 = s_payload.end_y;
        end
        ctx0_next.live = !(max_x_reg < ctx0_next.x1) && !(ctx0_next.x2 < min_x_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctx0_reg <= ctx0_next;
        end
    end

    lsrc_interp u_clip_left (
        .aclk (aclk), .aresetn (aresetn), .adv (adv),
        .valid_i (v0_reg), .ctx_i (ctx0_reg),
        .base_i (ctx0_reg.y2),
        .a1_i (ctx0_reg.y1), .a2_i (ctx0_reg.y2),
        .b1_i (min_x_reg),   .b2_i (ctx0_reg.x2),
        .c1_i (ctx0_reg.x1), .c2_i (ctx0_reg.x2),
        .valid_o (va), .ctx_o (ca), .res_o (ra)
    );

    always_comb begin
        ca_next = ca;
        if (ca.x1 < min_x_reg) begin
            ca_next.y1 = ra;
            ca_next.x1 = min_x_reg;
        end
    end

    lsrc_interp u_clip_right (
        .aclk (aclk), .aresetn (aresetn), .adv (adv),
        .valid_i (va), .ctx_i (ca_next),
        .base_i (ca_next.y1),
        .a1_i (ca_next.y2), .a2_i (ca_next.y1),
        .b1_i (max_x_reg),  .b2_i (ca_next.x1),
        .c1_i (ca_next.x2), .c2_i (ca_next.x1),
        .valid_o (vb), .ctx_o (cb), .res_o (rb)
    );

    always_comb begin
        cb_next = cb;
        if (max_x_reg < cb.x2) begin
            cb_next.y2 = rb;
            cb_next.x2 = max_x_reg;
        end
        if ((cb_next.y1 < min_y_reg && cb_next.y2 < min_y_reg) ||
            (max_y_reg < cb_next.y1 && max_y_reg < cb_next.y2)) begin
            cb_next.live = 1'b0;
        end
    end

    assign bound_c = (cb_next.y1 < min_y_reg) ? min_y_reg : max_y_reg;

    lsrc_interp u_clip_first (
        .aclk (aclk), .aresetn (aresetn), .adv (adv),
        .valid_i (vb), .ctx_i (cb_next),
        .base_i (cb_next.x2),
        .a1_i (cb_next.x1), .a2_i (cb_next.x2),
        .b1_i (cb_next.y2), .b2_i (bound_c),
        .c1_i (cb_next.y2), .c2_i (cb_next.y1),
        .valid_o (vc), .ctx_o (cc), .res_o (rc)
    );

    always_comb begin
        cc_next = cc;
        if (cc.y1 < min_y_reg) begin
            cc_next.x1 = rc;
            cc_next.y1 = min_y_reg;
        end else if (max_y_reg < cc.y1) begin
            cc_next.x1 = rc;
            cc_next.y1 = max_y_reg;
        end
    end

    assign bound_d = (cc_next.y2 < min_y_reg) ? min_y_reg : max_y_reg;

    lsrc_interp u_clip_second (
        .aclk (aclk), .aresetn (aresetn), .adv (adv),
        .valid_i (vc), .ctx_i (cc_next),
        .base_i (cc_next.x1),
        .a1_i (cc_next.x2), .a2_i (cc_next.x1),
        .b1_i (cc_next.y1), .b2_i (bound_d),
        .c1_i (cc_next.y1), .c2_i (cc_next.y2),
        .valid_o (vd), .ctx_o (cd), .res_o (rd)
    );

    always_comb begin
        cd_next = cd;
        if (cd.y2 < min_y_reg) begin
            cd_next.x2 = rd;
            cd_next.y2 = min_y_reg;
        end else if (max_y_reg < cd.y2) begin
            cd_next.x2 = rd;
            cd_next.y2 = max_y_reg;
        end
    end

    always_comb begin
        m_payload_next.visible = cd_next.live;
        if (!cd_next.live) begin
            m_payload_next.clip_start_x = cd_next.item.start_x;
            m_payload_next.clip_start_y = cd_next.item.start_y;
            m_payload_next.clip_end_x   = cd_next.item.end_x;
            m_payload_next.clip_end_y   = cd_next.item.end_y;
        end else if (cd_next.swap) begin
            m_payload_next.clip_start_x = cd_next.x2;
            m_payload_next.clip_start_y = cd_next.y2;
            m_payload_next.clip_end_x   = cd_next.x1;
            m_payload_next.clip_end_y   = cd_next.y1;
        end else begin
            m_payload_next.clip_start_x = cd_next.x1;
            m_payload_next.clip_start_y = cd_next.y1;
            m_payload_next.clip_end_x   = cd_next.x2;
            m_payload_next.clip_end_y   = cd_next.y2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vd;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
endmodule
`default_nettype wire

// File: rtl/core/lsrc_checker.sv
// Port-level checker for the line segment rectangle clipper, bound to the top level.
// Depends on lsrc_pkg and line_segment_rect_clipper.
`default_nettype none
module lsrc_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire lsrc_pkg::lsrc_out_t m_payload,
    input wire logic                pready
);
    import lsrc_pkg::*;

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result dropped or changed");

    assert property (@(posedge aclk) pready)
        else $error("register port stalled");
endmodule

bind line_segment_rect_clipper lsrc_checker u_lsrc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload),
    .pready    (pready)
);
`default_nettype wire

// File: test/tb_line_segment_rect_clipper.sv
// Testbench for line_segment_rect_clipper: directed and random segments, region setups
// through the APB port, random idling on both channels and a long output stall.
// Depends on lsrc_pkg and the clipper RTL.
`default_nettype none
module tb_line_segment_rect_clipper;
    timeunit 1ns;
    timeprecision 1ps;
    import lsrc_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 450;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    lsrc_in_t s_payload;
    logic m_valid;
    logic m_ready;
    lsrc_out_t m_payload;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    coord_t win_min_x, win_max_x, win_min_y, win_max_y;
    lsrc_out_t clip_expect_q[$];
    int fail_count;
    int idle_cycles;
    int hold_off_cycles;
    bit no_idle;
    int sent_count, got_count, visible_count;

    line_segment_rect_clipper uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic coord_t interpolate(coord_t base, coord_t a1, coord_t a2,
                                           coord_t b1, coord_t b2, coord_t c1, coord_t c2);
        logic signed [127:0] wa1, wa2, wb1, wb2, wc1, wc2, wbase, num, den, quo, sum;
        wa1 = a1; wa2 = a2; wb1 = b1; wb2 = b2; wc1 = c1; wc2 = c2; wbase = base;
        den = wc1 - wc2;
        if (den == 0) return base;
        num = (wa1 - wa2) * (wb1 - wb2);
        quo = num / den;
        sum = wbase + quo;
        return coord_t'(sum[COORD_W-1:0]);
    endfunction

    function automatic lsrc_out_t clip_segment(lsrc_in_t seg);
        lsrc_out_t res;
        coord_t x1, y1, x2, y2;
        logic swap, vis;
        swap = seg.end_x < seg.start_x;
        x1 = swap ? seg.end_x : seg.start_x;
        y1 = swap ? seg.end_y : seg.start_y;
        x2 = swap ? seg.start_x : seg.end_x;
        y2 = swap ? seg.start_y : seg.end_y;
        vis = 1'b1;
        if (win_max_x < x1 || x2 < win_min_x) begin
            vis = 1'b0;
        end else begin
            if (x1 < win_min_x) begin
                y1 = interpolate(y2, y1, y2, win_min_x, x2, x1, x2);
                x1 = win_min_x;
            end
            if (win_max_x < x2) begin
                y2 = interpolate(y1, y2, y1, win_max_x, x1, x2, x1);
                x2 = win_max_x;
            end
            if ((y1 < win_min_y && y2 < win_min_y) || (win_max_y < y1 && win_max_y < y2)) begin
                vis = 1'b0;
            end else begin
                if (y1 < win_min_y) begin
                    x1 = interpolate(x2, x1, x2, y2, win_min_y, y2, y1);
                    y1 = win_min_y;
                end else if (win_max_y < y1) begin
                    x1 = interpolate(x2, x1, x2, y2, win_max_y, y2, y1);
                    y1 = win_max_y;
                end
                if (y2 < win_min_y) begin
                    x2 = interpolate(x1, x2, x1, y1, win_min_y, y1, y2);
                    y2 = win_min_y;
                end else if (win_max_y < y2) begin
                    x2 = interpolate(x1, x2, x1, y1, win_max_y, y1, y2);
                    y2 = win_max_y;
                end
            end
        end
        res.visible = vis;
        if (!vis) begin
            res.clip_start_x = seg.start_x;
            res.clip_start_y = seg.start_y;
            res.clip_end_x = seg.end_x;
            res.clip_end_y = seg.end_y;
        end else if (swap) begin
            res.clip_start_x = x2;
            res.clip_start_y = y2;
            res.clip_end_x = x1;
            res.clip_end_y = y1;
        end else begin
            res.clip_start_x = x1;
            res.clip_start_y = y1;
            res.clip_end_x = x2;
            res.clip_end_y = y2;
        end
        return res;
    endfunction

    task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        lsrc_in_t seg;
        seg.start_x = sx;
        seg.start_y = sy;
        seg.end_x = ex;
        seg.end_y = ey;
        if (!no_idle && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= seg;
        do @(posedge aclk); while (!s_ready);
        clip_expect_q = {clip_expect_q, clip_segment(seg)};
        sent_count++;
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        end_burst();
        wait (clip_expect_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_region(logic [1:0] idx, coord_t value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_X: win_min_x = value;
            REG_MAX_X: win_max_x = value;
            REG_MIN_Y: win_min_y = value;
            REG_MAX_Y: win_max_y = value;
            default: ;
        endcase
    endtask

    task automatic set_region(coord_t x0, coord_t x1, coord_t y0, coord_t y1);
        write_region(REG_MIN_X, x0);
        write_region(REG_MAX_X, x1);
        write_region(REG_MIN_Y, y0);
        write_region(REG_MAX_Y, y1);
    endtask

    function automatic coord_t pick_coord(coord_t lo, coord_t hi);
        logic signed [63:0] span, v;
        case ($urandom_range(0, 3))
            0: return coord_t'($urandom);
            1: return $urandom_range(0, 1) ? lo : hi;
            default: begin
                span = 64'(hi) - 64'(lo);
                if (span < 0) span = -span;
                if (span > 64'sd100000) span = 64'sd100000;
                v = 64'(lo) + $signed(64'($urandom_range(0, 32'(span) * 2 + 40))) - span / 2 - 20;
                return coord_t'(v[COORD_W-1:0]);
            end
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count) begin
            send_segment(pick_coord(win_min_x, win_max_x), pick_coord(win_min_y, win_max_y),
                         pick_coord(win_min_x, win_max_x), pick_coord(win_min_y, win_max_y));
        end
    endtask

    task automatic test_directed();
        send_segment(100, 100, 200, 300);
        send_segment(-50, 10, -1, 20);
        send_segment(5000, 10, 4096, 20);
        send_segment(-1000, 2000, 6000, 2100);
        send_segment(6000, 2100, -1000, 2000);
        send_segment(10, -5, 20, -1);
        send_segment(10, 5000, 20, 4096);
        send_segment(100, -100, 300, 5000);
        send_segment(300, 5000, 100, -100);
        send_segment(500, -200, 500, 5000);
        send_segment(500, 700, 500, 800);
        send_segment(-100, 4000, 100, 5000);
        send_segment(-2000, 100, 100, -3000);
        send_segment(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        send_segment(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_segment(32'sh80000000, 0, 32'sh80000000, 0);
        send_segment(0, 0, 4095, 4095);
        send_segment(4095, 0, 0, 4095);
        wait_drained();
    endtask

    task automatic test_region_extremes();
        set_region(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send_segment(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_random(15);
        wait_drained();
        set_region(-3, 3, -3, 3);
        send_segment(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        send_segment(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_random(20);
        wait_drained();
        // inverted region, divisor can be zero
        set_region(50, -50, 40, -40);
        send_segment(-50, 10, 50, 10);
        send_segment(0, 0, 0, 0);
        send_segment(50, 40, 50, -40);
        send_random(20);
        wait_drained();
        set_region(7, 7, 9, 9);
        send_random(15);
        wait_drained();
    endtask

    task automatic test_random_regions();
        coord_t a, b, c, d;
        for (int i = 0; i < 8; i++) begin
            a = coord_t'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000) - 2000);
            b = coord_t'(a + $urandom_range(0, 5000));
            c = coord_t'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000) - 2000);
            d = coord_t'(c + $urandom_range(0, 5000));
            set_region(a, b, c, d);
            no_idle = (i == 3);
            send_random(20);
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        set_region(-1000, 1000, -500, 500);
        no_idle = 1'b1;
        hold_off_cycles = 1500;
        send_random(450);
        wait_drained();
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        lsrc_out_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_count++;
                if (clip_expect_q.size() == 0) begin
                    $error("result with no segment outstanding");
                    fail_count++;
                end else begin
                    exp_res = clip_expect_q.pop_front();
                    if (m_payload.visible) visible_count++;
                    if (m_payload.visible !== exp_res.visible) begin
                        $error("visible: expected %0d got %0d", exp_res.visible,
                               m_payload.visible);
                        fail_count++;
                    end
                    if (m_payload.clip_start_x !== exp_res.clip_start_x) begin
                        $error("clip_start_x: expected %0d got %0d", exp_res.clip_start_x,
                               m_payload.clip_start_x);
                        fail_count++;
                    end
                    if (m_payload.clip_start_y !== exp_res.clip_start_y) begin
                        $error("clip_start_y: expected %0d got %0d", exp_res.clip_start_y,
                               m_payload.clip_start_y);
                        fail_count++;
                    end
                    if (m_payload.clip_end_x !== exp_res.clip_end_x) begin
                        $error("clip_end_x: expected %0d got %0d", exp_res.clip_end_x,
                               m_payload.clip_end_x);
                        fail_count++;
                    end
                    if (m_payload.clip_end_y !== exp_res.clip_end_y) begin
                        $error("clip_end_y: expected %0d got %0d", exp_res.clip_end_y,
                               m_payload.clip_end_y);
                        fail_count++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 9);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        idle_cycles = 0;
        hold_off_cycles = 0;
        no_idle = 1'b0;
        sent_count = 0;
        got_count = 0;
        visible_count = 0;
        win_min_x = RST_MIN_X;
        win_max_x = RST_MAX_X;
        win_min_y = RST_MIN_Y;
        win_max_y = RST_MAX_Y;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_region_extremes();
        test_random_regions();
        test_output_stall();
        $display("Clipped %0d segments (%0d visible) over default, extreme, inverted",
                 got_count, visible_count);
        $display("and random regions, with random idling and a long output stall.");
        if (fail_count == 0 && clip_expect_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: line_segment_rect_clipper.f
rtl/core/lsrc_pkg.sv
rtl/core/lsrc_mul_cell.sv
rtl/core/lsrc_div_cell.sv
rtl/core/lsrc_interp.sv
rtl/core/line_segment_rect_clipper.sv
rtl/core/lsrc_checker.sv
test/tb_line_segment_rect_clipper.sv
